>>> rtl/core/frgs_pkg.sv
// ----------------------------------------------------------------------------
// Falling-rock grid step package
// Shared opcodes, register indexes, controller states and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package frgs_pkg;

	// Operation codes carried by the opcode input.
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_TICK   = 2'd1,
		OP_SETTLE = 2'd2,
		OP_READ   = 2'd3
	} opcode_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MAX_ROCKS   = 2'd2;

	// Register reset values.
	localparam logic [6:0] GRID_WIDTH_RST  = 7'd64;
	localparam logic [6:0] GRID_HEIGHT_RST = 7'd64;
	localparam logic [2:0] MAX_ROCKS_RST   = 3'd2;

	// Cell encoding and tick counter limit.
	localparam logic [3:0]  TABLE_CODE = 4'hF;
	localparam logic [11:0] TICK_SAT   = 12'hFFF;

	// Controller states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_TICK_START,
		ST_RD_UP,
		ST_RD_DN,
		ST_EVAL,
		ST_WR_DN,
		ST_TICK_END,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clr_write;
		logic cell_write;
		logic cell_read;
		logic tick_start;
		logic rd_dn;
		logic eval;
		logic wr_dn;
		logic advance;
		logic tick_end;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic    clear_last;
		logic    sweep_empty;
		logic    last_cell;
		logic    move;
		logic    moved;
		opcode_t op;
	} dp_status_t;

endpackage

>>> rtl/core/frgs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module frgs_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/frgs_ctrl.sv
// ----------------------------------------------------------------------------
// Falling-rock grid step controller
// Sequences the clearing pass, cell writes and reads, and the gravity sweep
// one cell at a time, and issues commands to the datapath.
// ----------------------------------------------------------------------------
module frgs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            opcode,
	input  frgs_pkg::dp_status_t  status,
	output frgs_pkg::ctrl_cmd_t   cmd,
	output logic                  busy
);

	import frgs_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (opcode_t'(opcode))
						OP_WRITE:  state_nxt = ST_WRITE;
						OP_READ:   state_nxt = ST_READ;
						OP_TICK:   state_nxt = ST_TICK_START;
						OP_SETTLE: state_nxt = ST_TICK_START;
						default:   state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_WRITE: state_nxt = ST_DONE;
			ST_READ:  state_nxt = ST_DONE;
			ST_TICK_START: begin
				state_nxt = status.sweep_empty ? ST_TICK_END : ST_RD_UP;
			end
			ST_RD_UP: state_nxt = ST_RD_DN;
			ST_RD_DN: state_nxt = ST_EVAL;
			ST_EVAL: begin
				if (status.move) begin
					state_nxt = ST_WR_DN;
				end else if (status.last_cell) begin
					state_nxt = ST_TICK_END;
				end else begin
					state_nxt = ST_RD_UP;
				end
			end
			ST_WR_DN: begin
				state_nxt = status.last_cell ? ST_TICK_END : ST_RD_UP;
			end
			ST_TICK_END: begin
				if (status.op == OP_SETTLE && status.moved) begin
					state_nxt = ST_TICK_START;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd            = '0;
		busy           = (state_q != ST_IDLE);
		cmd.capture    = (state_q == ST_IDLE) && start;
		cmd.clr_write  = (state_q == ST_CLEAR);
		cmd.cell_write = (state_q == ST_WRITE);
		cmd.cell_read  = (state_q == ST_READ);
		cmd.tick_start = (state_q == ST_TICK_START);
		cmd.rd_dn      = (state_q == ST_RD_DN);
		cmd.eval       = (state_q == ST_EVAL);
		cmd.wr_dn      = (state_q == ST_WR_DN);
		cmd.advance    = ((state_q == ST_EVAL) && !status.move) || (state_q == ST_WR_DN);
		cmd.tick_end   = (state_q == ST_TICK_END);
		cmd.finish     = (state_q == ST_DONE);
	end

endmodule

>>> rtl/core/frgs_dpath.sv
// ----------------------------------------------------------------------------
// Falling-rock grid step datapath
// Holds the configuration registers, the cell memory, the sweep counters,
// the rock transfer arithmetic and the result registers.
// ----------------------------------------------------------------------------
module frgs_dpath #(
	parameter int unsigned MAX_COLS = 64,
	parameter int unsigned MAX_ROWS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [6:0]           cfg_data,
	input  logic [1:0]           opcode,
	input  logic [5:0]           row_index,
	input  logic [5:0]           col_index,
	input  logic signed [3:0]    cell_value,
	input  frgs_pkg::ctrl_cmd_t  cmd,
	output frgs_pkg::dp_status_t status,
	output logic signed [3:0]    read_value,
	output logic                 grid_changed,
	output logic [11:0]          tick_count,
	output logic                 done
);

	import frgs_pkg::*;

	localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned RW    = $clog2(MAX_ROWS);
	localparam int unsigned CW    = $clog2(MAX_COLS);
	localparam int unsigned RNW   = $clog2(MAX_ROWS + 1);
	localparam int unsigned CNW   = $clog2(MAX_COLS + 1);

	// Configuration registers.
	logic [6:0] grid_width_q;
	logic [6:0] grid_height_q;
	logic [2:0] max_rocks_q;

	// Transaction registers.
	opcode_t        op_q;
	logic           in_grid_q;
	logic [AW-1:0]  addr_q;
	logic [3:0]     wval_q;
	logic [11:0]    count_q;
	logic           moved_q;

	// Sweep registers.
	logic [AW-1:0]  clr_addr_q;
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [3:0]     here_q;
	logic [3:0]     dn_new_q;

	// Result registers.
	logic           done_q;
	logic [3:0]     read_value_q;
	logic           grid_changed_q;
	logic [11:0]    tick_count_q;

	logic [CNW-1:0] used_cols;
	logic [RNW-1:0] used_rows;
	logic [AW-1:0]  up_addr;
	logic [AW-1:0]  dn_addr;
	logic           last_col;
	logic           last_row;
	logic           in_grid;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [3:0]     ram_wdata;
	logic [AW-1:0]  ram_raddr;
	logic [3:0]     ram_rdata;

	logic           move;
	logic [2:0]     room;
	logic [2:0]     fall;
	logic [3:0]     here_new;
	logic [3:0]     below_new;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			max_rocks_q   <= MAX_ROCKS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				REG_MAX_ROCKS:   max_rocks_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Grid size in use: zero counts as one, larger sizes are clamped to the storage.
	always_comb begin
		if (grid_width_q == '0) begin
			used_cols = CNW'(1);
		end else if (32'(grid_width_q) > MAX_COLS) begin
			used_cols = CNW'(MAX_COLS);
		end else begin
			used_cols = CNW'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			used_rows = RNW'(1);
		end else if (32'(grid_height_q) > MAX_ROWS) begin
			used_rows = RNW'(MAX_ROWS);
		end else begin
			used_rows = RNW'(grid_height_q);
		end
	end

	// Addressed cell check for writes and reads.
	assign in_grid = (32'(row_index) < 32'(used_rows)) && (32'(col_index) < 32'(used_cols));

	// Sweep addresses and position flags.
	assign up_addr  = AW'(32'(row_q) * MAX_COLS + 32'(col_q));
	assign dn_addr  = AW'(32'(up_addr) + MAX_COLS);
	assign last_col = (32'(col_q) + 32'd1) == 32'(used_cols);
	assign last_row = (32'(row_q) + 32'd2) == 32'(used_rows);

	// Rock transfer: here_q holds the upper cell, the memory returns the lower.
	always_comb begin
		move      = !here_q[3] && (here_q[2:0] != 3'd0) &&
		            !ram_rdata[3] && (ram_rdata[2:0] < max_rocks_q);
		room      = max_rocks_q - ram_rdata[2:0];
		fall      = (here_q[2:0] < room) ? here_q[2:0] : room;
		here_new  = {1'b0, here_q[2:0] - fall};
		below_new = {1'b0, ram_rdata[2:0] + fall};
	end

	// Transaction capture, tick bookkeeping and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= OP_WRITE;
			count_q    <= '0;
			moved_q    <= 1'b0;
			clr_addr_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else begin
			if (cmd.capture) begin
				op_q    <= opcode_t'(opcode);
				count_q <= '0;
			end
			if (cmd.clr_write) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.tick_start) begin
				row_q   <= '0;
				col_q   <= '0;
				moved_q <= 1'b0;
			end
			if (cmd.eval && move) begin
				moved_q <= 1'b1;
			end
			if (cmd.advance) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (cmd.tick_end && count_q != TICK_SAT) begin
				count_q <= count_q + 12'd1;
			end
		end
	end

	// Payload registers of the current transaction and cell.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_grid_q <= in_grid;
			addr_q    <= AW'(32'(row_index) * MAX_COLS + 32'(col_index));
			wval_q    <= cell_value[3] ? TABLE_CODE : cell_value;
		end
		if (cmd.rd_dn) begin
			here_q <= ram_rdata;
		end
		if (cmd.eval) begin
			dn_new_q <= below_new;
		end
	end

	// Memory port selection.
	always_comb begin
		ram_we    = cmd.clr_write || (cmd.cell_write && in_grid_q) ||
		            (cmd.eval && move) || cmd.wr_dn;
		ram_waddr = dn_addr;
		ram_wdata = dn_new_q;
		if (cmd.clr_write) begin
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (cmd.cell_write) begin
			ram_waddr = addr_q;
			ram_wdata = wval_q;
		end else if (cmd.eval) begin
			ram_waddr = up_addr;
			ram_wdata = here_new;
		end
		if (cmd.cell_read) begin
			ram_raddr = addr_q;
		end else if (cmd.rd_dn) begin
			ram_raddr = dn_addr;
		end else begin
			ram_raddr = up_addr;
		end
	end

	frgs_ram #(
		.WIDTH (4),
		.DEPTH (DEPTH)
	) u_grid_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	// Result fields; only the field of the finished opcode can be nonzero.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			read_value_q   <= (op_q == OP_READ && in_grid_q) ? ram_rdata : 4'd0;
			grid_changed_q <= (op_q == OP_TICK) ? moved_q : 1'b0;
			tick_count_q   <= (op_q == OP_SETTLE) ? count_q : 12'd0;
		end
	end

	// Status to the controller.
	always_comb begin
		status.clear_last  = (clr_addr_q == AW'(DEPTH - 1));
		status.sweep_empty = (used_rows < RNW'(2));
		status.last_cell   = last_col && last_row;
		status.move        = move;
		status.moved       = moved_q;
		status.op          = op_q;
	end

	assign done         = done_q;
	assign read_value   = $signed(read_value_q);
	assign grid_changed = grid_changed_q;
	assign tick_count   = tick_count_q;

endmodule

>>> rtl/core/falling_rock_grid_step.sv
// ----------------------------------------------------------------------------
// Falling-rock grid step
// A grid of cells, each a fixed table or a pile of rocks, with cell write,
// cell read, one gravity tick and run-until-stable operations.
// ----------------------------------------------------------------------------
// After reset the block clears its MAX_ROWS*MAX_COLS-entry cell memory one
// entry a cycle and holds busy high until that pass ends; configuration writes
// are taken at any time. A transaction is taken when start is high and busy is
// low, and its single result appears on the result ports with done high for
// exactly one cycle, which the receiver must take then. A cell write or read
// passes through its own state and the done state before done rises. A gravity
// tick walks the used grid one cell at a time through the single-read-port cell
// memory: for each of grid_width*(grid_height-1) cells it reads the upper cell,
// reads the lower cell and evaluates, and rewrites both cells when rocks fall,
// between a tick start and a tick end state; a run-until-stable transaction
// repeats that for every tick it counts.
// ----------------------------------------------------------------------------
module falling_rock_grid_step #(
	parameter int unsigned MAX_COLS = 64,
	parameter int unsigned MAX_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic [5:0]        row_index,
	input  logic [5:0]        col_index,
	input  logic signed [3:0] cell_value,
	output logic              done,
	output logic signed [3:0] read_value,
	output logic              grid_changed,
	output logic [11:0]       tick_count
);

	import frgs_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	frgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	frgs_dpath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.row_index    (row_index),
		.col_index    (col_index),
		.cell_value   (cell_value),
		.cmd          (cmd),
		.status       (status),
		.read_value   (read_value),
		.grid_changed (grid_changed),
		.tick_count   (tick_count),
		.done         (done)
	);

	// A taken transaction keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after a transaction was taken");

	// A result only follows a busy cycle, and never arrives twice in a row.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !$past(done)))
		else $error("result strobe without a transaction in flight");

	// At most one result field is nonzero.
	a_fields_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($countones({read_value != 4'sd0, grid_changed, tick_count != 12'd0}) <= 1))
		else $error("more than one result field is nonzero");

	// A cell is never evaluated on a grid with fewer than two rows.
	a_eval_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> !status.sweep_empty)
		else $error("cell evaluated on a grid with no sweep rows");

endmodule

>>> sim/falling_rock_grid_step_test.sv
// ----------------------------------------------------------------------------
// Falling-rock grid step testbench
// Drives cell writes, cell reads, single gravity ticks and run-until-stable
// transactions into the grid block. It also moves the grid size and the rock
// capacity between phases. A scoreboard keeps its own copy of the grid and
// checks every result against it, field by field.
// ----------------------------------------------------------------------------
module falling_rock_grid_step_test;
	timeunit 1ns;
	timeprecision 1ps;
	import frgs_pkg::*;

	localparam int unsigned GRID_COLS   = 64;
	localparam int unsigned GRID_ROWS   = 64;
	localparam int unsigned ITEM_TARGET = 140;
	// Index with no register behind it.
	localparam logic [1:0]  REG_SPARE   = 2'd3;

	typedef struct {
		logic signed [3:0] read_value;
		logic              grid_changed;
		logic [11:0]       tick_count;
	} grid_outcome_t;

	// Scoreboard: a private copy of the grid and its registers, and the results
	// that the accepted transactions still owe.
	class rock_grid_ledger;
		logic signed [3:0] cells [GRID_ROWS * GRID_COLS];
		logic [6:0]        width_reg;
		logic [6:0]        height_reg;
		logic [2:0]        rocks_cap;
		grid_outcome_t     outcomes_due [$];
		int unsigned       mismatch_count;

		function new();
			foreach (cells[i]) cells[i] = 4'sd0;
			width_reg = GRID_WIDTH_RST;
			height_reg = GRID_HEIGHT_RST;
			rocks_cap = MAX_ROCKS_RST;
			mismatch_count = 0;
		endfunction

		function int unsigned used_cols();
			if (width_reg < 7'd1) return 1;
			if (32'(width_reg) > GRID_COLS) return GRID_COLS;
			return 32'(width_reg);
		endfunction

		function int unsigned used_rows();
			if (height_reg < 7'd1) return 1;
			if (32'(height_reg) > GRID_ROWS) return GRID_ROWS;
			return 32'(height_reg);
		endfunction

		function int unsigned outcomes_left();
			return outcomes_due.size();
		endfunction

		function void set_register(logic [1:0] index, logic [6:0] data);
			case (index)
				REG_GRID_WIDTH: width_reg = data;
				REG_GRID_HEIGHT: height_reg = data;
				REG_MAX_ROCKS: rocks_cap = data[2:0];
				default: ;
			endcase
		endfunction

		// One in-place sweep, top row first, so rocks may drop several rows.
		function bit gravity_sweep();
			int unsigned cols, rows, r, c, upper, lower;
			int here, below, room, fall;
			bit moved;
			cols = used_cols();
			rows = used_rows();
			moved = 1'b0;
			for (r = 0; r + 1 < rows; r++) begin
				for (c = 0; c < cols; c++) begin
					upper = r * GRID_COLS + c;
					lower = upper + GRID_COLS;
					here = cells[upper];
					below = cells[lower];
					if (here > 0 && below >= 0 && below < int'(rocks_cap)) begin
						room = int'(rocks_cap) - below;
						fall = (here < room) ? here : room;
						cells[upper] = 4'(here - fall);
						cells[lower] = 4'(below + fall);
						moved = 1'b1;
					end
				end
			end
			return moved;
		endfunction

		// Applies one accepted transaction and queues the result it owes.
		function void take_command(opcode_t op, logic [5:0] row, logic [5:0] col,
				logic signed [3:0] value);
			grid_outcome_t outcome;
			bit in_grid, moved;
			int unsigned spot, ticks;
			outcome.read_value = 4'sd0;
			outcome.grid_changed = 1'b0;
			outcome.tick_count = 12'd0;
			in_grid = (32'(row) < used_rows()) && (32'(col) < used_cols());
			spot = 32'(row) * GRID_COLS + 32'(col);
			case (op)
				OP_WRITE: if (in_grid) cells[spot] = value[3] ? TABLE_CODE : value;
				OP_TICK: outcome.grid_changed = gravity_sweep();
				OP_SETTLE: begin
					ticks = 0;
					do begin
						moved = gravity_sweep();
						if (ticks < 32'(TICK_SAT)) ticks++;
					end while (moved);
					outcome.tick_count = 12'(ticks);
				end
				default: if (in_grid) outcome.read_value = cells[spot];
			endcase
			outcomes_due.push_back(outcome);
		endfunction

		// Compares one result with the oldest one owed.
		function void check_outcome(logic signed [3:0] rd, logic chg, logic [11:0] ticks);
			grid_outcome_t want;
			if (outcomes_due.size() == 0) begin
				$display("%0t ns: result with no transaction pending: read_value %0d",
					$time, rd, " grid_changed %0b tick_count %0d", chg, ticks);
				mismatch_count++;
				return;
			end
			want = outcomes_due.pop_front();
			if (rd !== want.read_value) begin
				$display("%0t ns: read_value expected %0d actual %0d",
					$time, want.read_value, rd);
				mismatch_count++;
			end
			if (chg !== want.grid_changed) begin
				$display("%0t ns: grid_changed expected %0b actual %0b",
					$time, want.grid_changed, chg);
				mismatch_count++;
			end
			if (ticks !== want.tick_count) begin
				$display("%0t ns: tick_count expected %0d actual %0d",
					$time, want.tick_count, ticks);
				mismatch_count++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_write;
	logic [1:0]        cfg_index;
	logic [6:0]        cfg_data;
	logic              start;
	logic              busy;
	logic [1:0]        opcode;
	logic [5:0]        row_index;
	logic [5:0]        col_index;
	logic signed [3:0] cell_value;
	logic              done;
	logic signed [3:0] read_value;
	logic              grid_changed;
	logic [11:0]       tick_count;

	rock_grid_ledger ledger;
	int unsigned     items_sent;
	int unsigned     burst_left;

	falling_rock_grid_step #(
		.MAX_COLS(GRID_COLS),
		.MAX_ROWS(GRID_ROWS)
	) uut (.*);

	always begin
		#1;
		clk = 1'b1;
		#1;
		clk = 1'b0;
	end

	// Watch both sides of the block at each rising edge.
	always @(posedge clk) begin
		if (done === 1'b1) ledger.check_outcome(read_value, grid_changed, tick_count);
		if (start === 1'b1 && busy === 1'b0) begin
			ledger.take_command(opcode_t'(opcode), row_index, col_index, cell_value);
		end
		if (cfg_write === 1'b1) ledger.set_register(cfg_index, cfg_data);
	end

	// Presents one transaction and holds it until the block takes it.
	task automatic issue(opcode_t op, logic [5:0] row, logic [5:0] col,
			logic signed [3:0] value);
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		row_index <= row;
		col_index <= col;
		cell_value <= value;
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
	endtask

	// Sender gap; the idle fields carry noise the block must ignore.
	task automatic pause_sender(int unsigned cycles);
		@(negedge clk);
		start <= 1'b0;
		opcode <= 2'($urandom_range(0, 3));
		row_index <= 6'($urandom_range(0, 63));
		col_index <= 6'($urandom_range(0, 63));
		cell_value <= 4'($urandom_range(0, 15));
		repeat (cycles) @(negedge clk);
	endtask

	// Holds the sender off until every owed result has arrived.
	task automatic wait_for_outcomes();
		@(negedge clk);
		start <= 1'b0;
		while (ledger.outcomes_left() != 0 || busy !== 1'b0) @(negedge clk);
	endtask

	task automatic write_register(logic [1:0] index, logic [6:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Mostly small rock counts, some empty cells and some tables.
	function automatic logic signed [3:0] pick_cell_value();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) return 4'($urandom_range(8, 15));
		if (pick < 30) return 4'sd0;
		return 4'($urandom_range(1, 7));
	endfunction

	// One random transaction; while filling, writes dominate.
	task automatic random_command(bit filling);
		opcode_t op;
		logic [5:0] row, col;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (filling) begin
			op = (pick < 80) ? OP_WRITE : ((pick < 90) ? OP_READ : OP_TICK);
		end else begin
			if (pick < 30) op = OP_WRITE;
			else if (pick < 55) op = OP_READ;
			else if (pick < 78) op = OP_TICK;
			else op = OP_SETTLE;
		end
		if ($urandom_range(0, 9) == 0) row = 6'($urandom_range(0, 63));
		else row = 6'($urandom_range(0, ledger.used_rows() - 1));
		if ($urandom_range(0, 9) == 0) col = 6'($urandom_range(0, 63));
		else col = 6'($urandom_range(0, ledger.used_cols() - 1));
		issue(op, row, col, pick_cell_value());
	endtask

	// Bursts of back-to-back transactions separated by random gaps.
	task automatic sender_rhythm();
		if (burst_left == 0) begin
			pause_sender($urandom_range(0, 5));
			burst_left = $urandom_range(1, 6);
		end else begin
			burst_left--;
		end
	endtask

	task automatic directed_part();
		// Full default grid; the first transaction also waits out the clearing pass.
		issue(OP_WRITE, 6'd0, 6'd0, 4'sd7);
		issue(OP_WRITE, 6'd63, 6'd63, 4'sb1000);
		issue(OP_READ, 6'd63, 6'd63, 4'sd0);
		issue(OP_READ, 6'd0, 6'd0, 4'sd0);
		issue(OP_TICK, 6'd0, 6'd0, 4'sd0);
		issue(OP_SETTLE, 6'd0, 6'd0, 4'sd0);
		issue(OP_READ, 6'd63, 6'd0, 4'sd0);
		wait_for_outcomes();

		// Zero width clamps to one column; oversized height clamps to the maximum.
		write_register(REG_GRID_WIDTH, 7'd0);
		write_register(REG_GRID_HEIGHT, 7'd127);
		write_register(REG_MAX_ROCKS, 7'd7);
		issue(OP_WRITE, 6'd5, 6'd0, 4'sd7);
		issue(OP_WRITE, 6'd5, 6'd1, 4'sd3);
		issue(OP_READ, 6'd5, 6'd1, 4'sd0);
		issue(OP_READ, 6'd63, 6'd63, 4'sd0);
		issue(OP_TICK, 6'd0, 6'd0, 4'sd0);
		issue(OP_READ, 6'd63, 6'd0, 4'sd0);
		wait_for_outcomes();

		// A single row never changes.
		write_register(REG_GRID_WIDTH, 7'd127);
		write_register(REG_GRID_HEIGHT, 7'd0);
		write_register(REG_MAX_ROCKS, 7'd1);
		issue(OP_TICK, 6'd0, 6'd0, 4'sd0);
		issue(OP_SETTLE, 6'd0, 6'd0, 4'sd0);
		wait_for_outcomes();

		// Zero capacity: nothing may fall, even over empty cells.
		write_register(REG_SPARE, 7'h55);
		write_register(REG_GRID_WIDTH, 7'd3);
		write_register(REG_GRID_HEIGHT, 7'd4);
		write_register(REG_MAX_ROCKS, 7'h78);
		issue(OP_WRITE, 6'd1, 6'd1, 4'sb1111);
		issue(OP_WRITE, 6'd0, 6'd1, 4'sd6);
		issue(OP_WRITE, 6'd0, 6'd2, 4'sd7);
		issue(OP_TICK, 6'd0, 6'd0, 4'sd0);
		wait_for_outcomes();

		// Capacity five; the overfull cell over the table stays put.
		write_register(REG_MAX_ROCKS, 7'h7D);
		issue(OP_SETTLE, 6'd0, 6'd0, 4'sd0);
		issue(OP_READ, 6'd0, 6'd2, 4'sd0);
		issue(OP_READ, 6'd3, 6'd2, 4'sd0);
		issue(OP_READ, 6'd0, 6'd1, 4'sd0);
	endtask

	task automatic random_part();
		int unsigned phase_items, shape, k;
		bit gaps_on;
		while (items_sent < ITEM_TARGET) begin
			wait_for_outcomes();
			// Mostly small grids; now and then a wide, tall or degenerate one.
			shape = $urandom_range(0, 9);
			case (shape)
				0: begin
					write_register(REG_GRID_WIDTH, 7'($urandom_range(64, 127)));
					write_register(REG_GRID_HEIGHT, 7'($urandom_range(1, 3)));
				end
				1: begin
					write_register(REG_GRID_WIDTH, 7'($urandom_range(1, 2)));
					write_register(REG_GRID_HEIGHT, 7'($urandom_range(60, 127)));
				end
				2: begin
					write_register(REG_GRID_WIDTH, 7'($urandom_range(0, 4)));
					write_register(REG_GRID_HEIGHT, 7'($urandom_range(0, 4)));
				end
				default: begin
					write_register(REG_GRID_WIDTH, 7'($urandom_range(1, 8)));
					write_register(REG_GRID_HEIGHT, 7'($urandom_range(1, 8)));
				end
			endcase
			write_register(REG_MAX_ROCKS, 7'($urandom_range(0, 127)));
			phase_items = $urandom_range(8, 16);
			gaps_on = ($urandom_range(0, 3) != 0);
			for (k = 0; k < phase_items; k++) begin
				random_command(k < phase_items / 2);
				if (gaps_on) sender_rhythm();
			end
		end
	endtask

	initial begin
		ledger = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_GRID_WIDTH;
		cfg_data = 7'd0;
		start = 1'b0;
		opcode = OP_WRITE;
		row_index = 6'd0;
		col_index = 6'd0;
		cell_value = 4'sd0;
		items_sent = 0;
		burst_left = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		directed_part();
		random_part();
		wait_for_outcomes();
		repeat (20) @(negedge clk);
		if (ledger.mismatch_count == 0 && ledger.outcomes_left() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
